@@ sv/teq_pkg.sv @@
// Shared types and codes for the timed event queue.
// No dependencies; every other file imports this package.
package teq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned PAY_W     = 16;
	localparam int unsigned FILL_W    = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_POPPED   = 2'd2,
		ST_NONE_DUE = 2'd3
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] tstamp;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	// One command per cycle, while req.ready is high, reaches every cell; ins and pop never both high.
	typedef struct packed {
		logic ins;
		logic pop;
	} ctl_t;

endpackage

@@ sv/teq_req_if.sv @@
// Request channel of the timed event queue: valid/ready plus one command word.
// Depends on teq_pkg.
interface teq_req_if import teq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [TIME_W-1:0] stamp;
	logic [PAY_W-1:0]  payload;

	modport source (output valid, cmd, stamp, payload, input ready);
	modport sink   (input valid, cmd, stamp, payload, output ready);
endinterface

@@ sv/teq_rsp_if.sv @@
// Response channel of the timed event queue: valid/ready plus one result word.
// Depends on teq_pkg.
interface teq_rsp_if import teq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [TIME_W-1:0] event_time;
	logic [PAY_W-1:0]  event_payload;
	logic [FILL_W-1:0] fill;

	modport source (output valid, status, event_time, event_payload, fill, input ready);
	modport sink   (input valid, status, event_time, event_payload, fill, output ready);
endinterface

@@ sv/timed_event_queue.sv @@
// Timed event queue: a row of DEPTH cells kept sorted by due time.
// A result is registered and appears in the cycle after its command is accepted.
// Throughput: one command per cycle unless a held result stalls req.ready; every
// cell compares its time with the stamp in parallel for insert and pop alike.
// Reset: asynchronous; all slots become empty, no result is pending.
module timed_event_queue import teq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	teq_req_if.sink   req,
	teq_rsp_if.source rsp
);

	localparam int unsigned OCC_W = $clog2(DEPTH + 1);

	logic   [DEPTH-1:0] valid_w;
	logic   [DEPTH-1:0] keep_w;
	entry_t             ent_w [DEPTH];

	logic              req_acc;
	logic              full;
	ctl_t              ctl;
	entry_t            new_ent;
	logic [OCC_W-1:0]  occ_q;
	logic [OCC_W-1:0]  occ_d;
	status_t           status_d;
	entry_t            out_ent_d;

	logic              rsp_valid_q;
	status_t           status_q;
	entry_t            out_ent_q;
	logic [FILL_W-1:0] fill_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_acc   = req.valid && req.ready;
	assign full      = valid_w[DEPTH-1];

	assign new_ent.tstamp  = req.stamp;
	assign new_ent.payload = req.payload;

	assign ctl.ins = req_acc && (cmd_t'(req.cmd) == CMD_INSERT) && !full;
	assign ctl.pop = req_acc && (cmd_t'(req.cmd) == CMD_POP) && keep_w[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   lv, lk, rv;
		entry_t le, re;
		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign lk = 1'b1;
			assign le = new_ent;
		end else begin : g_mid
			assign lv = valid_w[i-1];
			assign lk = keep_w[i-1];
			assign le = ent_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign re = ent_w[i];
		end else begin : g_body
			assign rv = valid_w[i+1];
			assign re = ent_w[i+1];
		end
		teq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_ent     (new_ent),
			.left_valid  (lv),
			.left_keep   (lk),
			.left_ent    (le),
			.right_valid (rv),
			.right_ent   (re),
			.valid       (valid_w[i]),
			.keep        (keep_w[i]),
			.ent         (ent_w[i])
		);
	end

	always_comb begin
		occ_d     = occ_q;
		out_ent_d = '0;
		if (cmd_t'(req.cmd) == CMD_INSERT) begin
			status_d = full ? ST_FULL : ST_INSERTED;
			if (!full) occ_d = occ_q + OCC_W'(1);
		end else if (keep_w[0]) begin
			status_d  = ST_POPPED;
			out_ent_d = ent_w[0];
			occ_d     = occ_q - OCC_W'(1);
		end else begin
			status_d = ST_NONE_DUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				occ_q       <= occ_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			status_q  <= status_d;
			out_ent_q <= out_ent_d;
			fill_q    <= FILL_W'(occ_d);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.event_time    = out_ent_q.tstamp;
	assign rsp.event_payload = out_ent_q.payload;
	assign rsp.fill          = fill_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above depth");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == 32'(occ_q))
		else $error("slot valid bits disagree with occupancy");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && cmd_t'(req.cmd) == CMD_INSERT && full)
		|=> (rsp.valid && status_q == ST_FULL && $stable(occ_q)))
		else $error("insert into full queue not rejected");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && cmd_t'(req.cmd) == CMD_POP && !valid_w[0])
		|=> (status_q == ST_NONE_DUE && occ_q == '0))
		else $error("pop on empty queue returned an event");

endmodule

@@ sv/teq_cell.sv @@
// One slot of the sorted event row; trades entries with its two neighbors.
// Depends on teq_pkg.
module teq_cell import teq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  entry_t            new_ent,
	input  logic              left_valid,
	input  logic              left_keep,
	input  entry_t            left_ent,
	input  logic              right_valid,
	input  entry_t            right_ent,
	output logic              valid,
	output logic              keep,
	output entry_t            ent
);

	logic   valid_q;
	entry_t ent_q;
	logic   valid_d;
	entry_t ent_d;

	// keep: this slot is stored and not later than the stamp
	assign keep  = valid_q && (ent_q.tstamp <= new_ent.tstamp);
	assign valid = valid_q;
	assign ent   = ent_q;

	always_comb begin
		valid_d = valid_q;
		ent_d   = ent_q;
		if (ctl.ins) begin
			if (!keep) begin
				if (left_keep) begin
					valid_d = 1'b1;
					ent_d   = new_ent;
				end else begin
					// shift right behind the insertion point
					valid_d = left_valid;
					ent_d   = left_ent;
				end
			end
		end else if (ctl.pop) begin
			valid_d = right_valid;
			ent_d   = right_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

@@ bench/teq_bench_pkg.sv @@
`timescale 1ns / 1ps
// Result predictor and scoreboard for the timed event queue bench.
// Depends on teq_pkg for the command, status and entry types.
package teq_bench_pkg;
	import teq_pkg::*;

	typedef struct {
		status_t            status;
		logic [TIME_W-1:0]  etime;
		logic [PAY_W-1:0]   epay;
		logic [FILL_W-1:0]  fill;
	} queue_result_t;

	class due_order_board;
		entry_t        held[$];    // stored events, earliest due time first
		queue_result_t awaited[$]; // results owed by the block, oldest first
		int unsigned   fault_count;

		function void report(string msg);
			fault_count++;
			if (fault_count <= 10) begin
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		// Apply one accepted command word to the shadow queue, owe its result.
		function void note_command(cmd_t c, logic [TIME_W-1:0] s, logic [PAY_W-1:0] p);
			queue_result_t r;
			entry_t        e;
			int unsigned   pos;
			r.status = ST_INSERTED;
			r.etime  = '0;
			r.epay   = '0;
			if (c == CMD_INSERT) begin
				if (held.size() >= DEPTH_DEF) begin
					r.status = ST_FULL;
				end else begin
					// go past every event due at or before the new one
					pos = 0;
					while (pos < held.size() && held[pos].tstamp <= s) pos++;
					e.tstamp = s;
					e.payload = p;
					held.insert(pos, e);
				end
			end else if (held.size() == 0 || held[0].tstamp > s) begin
				r.status = ST_NONE_DUE;
			end else begin
				e = held.pop_front();
				r.status = ST_POPPED;
				r.etime  = e.tstamp;
				r.epay   = e.payload;
			end
			r.fill = FILL_W'(held.size());
			awaited.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [TIME_W-1:0] t,
				logic [PAY_W-1:0] p, logic [FILL_W-1:0] f);
			queue_result_t w;
			if (awaited.size() == 0) begin
				report($sformatf("result word with nothing awaited: status %0d time %h payload %h fill %0d",
					st, t, p, f));
				return;
			end
			w = awaited.pop_front();
			if (st !== w.status || t !== w.etime || p !== w.epay || f !== w.fill) begin
				report($sformatf("expected status %0d time %h payload %h fill %0d, got status %0d time %h payload %h fill %0d",
					w.status, w.etime, w.epay, w.fill, st, t, p, f));
			end
		endfunction

		function void wrap_up();
			if (awaited.size() != 0) begin
				report($sformatf("%0d result words never arrived", awaited.size()));
				fault_count += awaited.size() - 1;
			end
		endfunction
	endclass

endpackage

@@ bench/timed_event_queue_tb.sv @@
`timescale 1ns / 1ps
// Top of the timed event queue bench: clock, reset, stimulus and checking.
// Depends on teq_pkg, the two channel interfaces and teq_bench_pkg.
module timed_event_queue_tb;
	import teq_pkg::*;
	import teq_bench_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 920;
	localparam int unsigned IDLE_LIMIT   = 3000;
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic clk;
	logic arst_n;
	int unsigned hold_asks;
	int unsigned burst_left;
	int unsigned idle_cycles;

	due_order_board board = new;

	teq_req_if req ();
	teq_rsp_if rsp ();

	timed_event_queue #(.DEPTH(DEPTH_DEF)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Offer one command word and hold it until the block takes it.
	task automatic send_word(cmd_t c, logic [TIME_W-1:0] s, logic [PAY_W-1:0] p);
		@(negedge clk);
		req.valid   = 1'b1;
		req.cmd     = c;
		req.stamp   = s;
		req.payload = p;
		do @(posedge clk); while (req.ready !== 1'b1);
		board.note_command(c, s, p);
	endtask

	// Send a word, then sometimes pause the request side when a burst runs out.
	task automatic offer(cmd_t c, logic [TIME_W-1:0] s, logic [PAY_W-1:0] p);
		int unsigned gap;
		send_word(c, s, p);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				@(negedge clk);
				req.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// Mostly a narrow window so equal and near times collide; sometimes extremes or any time.
	function automatic logic [TIME_W-1:0] pick_time(logic [TIME_W-1:0] base);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom;
			default: return base + $urandom_range(0, 15);
		endcase
	endfunction

	// Stimulus.
	initial begin
		int unsigned i;
		int unsigned seg_left;
		int unsigned ins_pct;
		logic [TIME_W-1:0] base;
		req.valid   = 1'b0;
		req.cmd     = CMD_INSERT;
		req.stamp   = '0;
		req.payload = '0;
		arst_n      = 1'b0;
		hold_asks   = 0;
		burst_left  = $urandom_range(1, 40);
		seg_left    = 0;
		ins_pct     = 50;
		base        = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		offer(CMD_POP, 32'd10, 16'h0000);          // pop on an empty queue
		offer(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		offer(CMD_INSERT, 32'd0, 16'h0000);
		offer(CMD_INSERT, 32'd5, 16'h1111);
		offer(CMD_INSERT, 32'd5, 16'h2222);        // equal time: must leave second
		offer(CMD_POP, 32'd4, 16'h0000);
		offer(CMD_POP, 32'd4, 16'h0000);           // head not yet due
		offer(CMD_POP, 32'd5, 16'h0000);
		offer(CMD_POP, 32'd5, 16'h0000);
		offer(CMD_POP, 32'hFFFF_FFFE, 16'h0000);
		offer(CMD_POP, 32'hFFFF_FFFF, 16'hFFFF);
		// fill to the brim, then one more insert must bounce
		for (i = 0; i <= DEPTH_DEF; i++) begin
			offer(CMD_INSERT, 32'($urandom_range(0, 40)), PAY_W'(i));
		end

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(40, 120);
				case ($urandom_range(0, 2))
					0: ins_pct = 15;
					1: ins_pct = 50;
					default: ins_pct = 85;
				endcase
				base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF0 : $urandom;
			end
			seg_left--;
			// starve the response side while requests keep coming
			if (i == 150 || i == 600) hold_asks++;
			if ($urandom_range(0, 99) < ins_pct) begin
				offer(CMD_INSERT, pick_time(base), PAY_W'($urandom));
			end else begin
				offer(CMD_POP, pick_time(base), PAY_W'($urandom));
			end
		end

		@(negedge clk);
		req.valid = 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.wrap_up();
		if (board.fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Response side back-pressure.
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned hold_len;
		int unsigned holds_done;
		rsp.ready  = 1'b0;
		mode       = RX_FREE;
		mode_left  = 0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_done != hold_asks) begin
				hold_len = $urandom_range(300, 500);
				rsp.ready = 1'b0;
				repeat (hold_len - 1) @(negedge clk);
				holds_done++;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_FREE:   rsp.ready = 1'b1;
					RX_COIN:   rsp.ready = $urandom_range(0, 1);
					RX_SPARSE: rsp.ready = ($urandom_range(0, 9) == 0);
					default:   rsp.ready = ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			board.check_result(rsp.status, rsp.event_time, rsp.event_payload, rsp.fill);
		end
	end

	// Give up when neither channel moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles + 1 >= IDLE_LIMIT) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
